// ----- hdl/stst_pkg.sv -----
// Shared types, codes and helpers of the sorted feed-time schedule table.
package stst_pkg;

  localparam int MAX_ENTRIES_DEF = 16;

  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int AMOUNT_W = 16;
  localparam int DM_W     = 11;

  localparam logic [HOUR_W-1:0]   HOUR_MAX     = 5'd23;
  localparam logic [MINUTE_W-1:0] MINUTE_MAX   = 6'd59;
  localparam logic [DM_W-1:0]     MIN_PER_HOUR = 11'd60;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;

  localparam logic [2:0] OP_INSERT  = 3'd0;
  localparam logic [2:0] OP_REMOVE  = 3'd1;
  localparam logic [2:0] OP_ADVANCE = 3'd2;
  localparam logic [2:0] OP_CLEAR   = 3'd3;
  localparam logic [2:0] OP_READ    = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_RANGE   = 3'd1;
  localparam logic [2:0] ST_DUP     = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_MISSING = 3'd4;
  localparam logic [2:0] ST_EMPTY   = 3'd5;

  typedef struct packed {
    logic [AMOUNT_W-1:0] amount;
    logic [MINUTE_W-1:0] minute;
    logic [HOUR_W-1:0]   hour;
  } entry_t;

  function automatic logic [DM_W-1:0] day_minute(input logic [HOUR_W-1:0] h,
                                                 input logic [MINUTE_W-1:0] m);
    day_minute = DM_W'(h) * MIN_PER_HOUR + DM_W'(m);
  endfunction

endpackage

// ----- hdl/sorted_time_schedule_table_core.sv -----
// Sorted feed-time schedule table with cursor, held in one synchronous memory.
//
// One word in, one word out per operation; a new word is taken only while the block
// is idle, but it is taken while the previous result still waits on the output side.
// The entries live in one memory with one write port and one registered read port,
// so the scan and the shift each move one entry per cycle. An insert scans for its
// place, shifts the later entries up and writes the new entry; a remove scans and
// shifts the later entries down; a duplicate, full-table or missing case stops after
// the scan; advance, clear, read and an out-of-range insert skip the scan. Every
// operation then reads the entry under the cursor and waits for the output register.
// Entries are never cleared after reset; only entries below the count are used.
module sorted_time_schedule_table_core #(
  parameter int MAX_ENTRIES = stst_pkg::MAX_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // op[2:0], hour[7:3], minute[13:8], amount[29:14], zero[31:30]
  input  logic [stst_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // status[2:0], position[6:3], entry_count[11:7], current_valid[12],
  // current_hour[17:13], current_minute[23:18], current_amount[39:24]
  output logic [stst_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_WRNEW = 3'd3;
  localparam logic [2:0] S_RDCUR = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0] state;

  // latched input word
  logic [2:0]                      op_r;
  logic [stst_pkg::HOUR_W-1:0]     hour_r;
  logic [stst_pkg::MINUTE_W-1:0]   minute_r;
  logic [stst_pkg::AMOUNT_W-1:0]   amount_r;

  logic [CNT_W-1:0] stored_count;
  logic [IDX_W-1:0] cursor;
  logic [IDX_W-1:0] pos;
  logic [2:0]       status;

  logic [CNT_W-1:0] idx;
  logic             chk_vld;
  logic [IDX_W-1:0] chk_idx;
  logic [CNT_W-1:0] sidx;
  logic [CNT_W-1:0] n_left;
  logic             mv_vld;
  logic [IDX_W-1:0] mv_dst;
  logic             m_valid;
  logic [stst_pkg::OUT_DATA_W-1:0] m_data;
  logic             fin_go;

  stst_pkg::entry_t entry_store [MAX_ENTRIES];
  stst_pkg::entry_t rd_data;
  stst_pkg::entry_t wr_data;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic             wr_en;

  // decoded input word
  logic [2:0]                    in_op;
  logic [stst_pkg::HOUR_W-1:0]   in_hour;
  logic [stst_pkg::MINUTE_W-1:0] in_minute;
  logic [stst_pkg::AMOUNT_W-1:0] in_amount;

  logic                   is_insert;
  logic [stst_pkg::DM_W-1:0] stored_dm;
  logic [stst_pkg::DM_W-1:0] in_dm;
  logic                   hit;
  logic                   scan_end;
  logic                   full;
  logic [CNT_W-1:0]       pos_cand;
  logic [CNT_W-1:0]       cnt_dec;
  logic [CNT_W-1:0]       cur_ext;
  logic [CNT_W-1:0]       cur_inc;
  logic [IDX_W-1:0]       adv_cursor;
  logic [IDX_W-1:0]       ins_cursor;
  logic [IDX_W-1:0]       rm_c1;
  logic [IDX_W-1:0]       rm_cursor;
  logic [CNT_W-1:0]       dst_up;
  logic [CNT_W-1:0]       dst_dn;
  logic [31:0]            pos_ext;
  logic [31:0]            cnt_ext;
  logic                   cur_valid;

  assign in_op     = s_axis_tdata[2:0];
  assign in_hour   = s_axis_tdata[7:3];
  assign in_minute = s_axis_tdata[13:8];
  assign in_amount = s_axis_tdata[29:14];

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = m_data;

  assign fin_go = (state == S_FIN) && (!m_valid || m_axis_tready);

  always_comb begin
    is_insert = (op_r == stst_pkg::OP_INSERT);
    stored_dm = stst_pkg::day_minute(rd_data.hour, rd_data.minute);
    in_dm     = stst_pkg::day_minute(hour_r, minute_r);
    hit       = chk_vld && (is_insert ? (stored_dm >= in_dm)
                                      : (rd_data.hour == hour_r &&
                                         rd_data.minute == minute_r));
    scan_end  = !chk_vld && (idx >= stored_count);
    full      = (stored_count == CNT_MAX);
    pos_cand  = hit ? CNT_W'(chk_idx) : stored_count;
    cnt_dec   = stored_count - CNT_W'(1);
    cur_ext   = CNT_W'(cursor);
    cur_inc   = cur_ext + CNT_W'(1);
    adv_cursor = (cur_inc >= stored_count) ? '0 : cur_inc[IDX_W-1:0];
    if (stored_count == '0) begin
      ins_cursor = '0;
    end else if (cursor >= pos) begin
      ins_cursor = cursor + IDX_W'(1);
    end else begin
      ins_cursor = cursor;
    end
    rm_c1     = (cursor > pos) ? cursor - IDX_W'(1) : cursor;
    rm_cursor = (CNT_W'(rm_c1) >= cnt_dec) ? '0 : rm_c1;
    dst_up    = sidx + CNT_W'(1);
    dst_dn    = sidx - CNT_W'(1);
    pos_ext   = 32'(pos);
    cnt_ext   = 32'(stored_count);
    cur_valid = (stored_count != '0);
  end

  // memory port control
  always_comb begin
    unique case (state)
      S_SCAN:  rd_addr = idx[IDX_W-1:0];
      S_SHIFT: rd_addr = sidx[IDX_W-1:0];
      default: rd_addr = cursor;
    endcase
    wr_en   = (state == S_SHIFT && mv_vld) || (state == S_WRNEW);
    wr_addr = (state == S_WRNEW) ? pos : mv_dst;
    if (state == S_WRNEW) begin
      wr_data.hour   = hour_r;
      wr_data.minute = minute_r;
      wr_data.amount = amount_r;
    end else begin
      wr_data = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= entry_store[rd_addr];
    if (wr_en) begin
      entry_store[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      stored_count <= '0;
      cursor       <= '0;
      m_valid      <= 1'b0;
      chk_vld      <= 1'b0;
      mv_vld       <= 1'b0;
    end else begin
      if (fin_go) begin
        m_valid <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op_r     <= in_op;
            hour_r   <= in_hour;
            minute_r <= in_minute;
            amount_r <= in_amount;
            pos      <= '0;
            idx      <= '0;
            chk_vld  <= 1'b0;
            status   <= stst_pkg::ST_OK;
            state    <= S_RDCUR;
            unique case (in_op)
              stst_pkg::OP_INSERT: begin
                if (in_hour > stst_pkg::HOUR_MAX || in_minute > stst_pkg::MINUTE_MAX) begin
                  status <= stst_pkg::ST_RANGE;
                end else begin
                  state <= S_SCAN;
                end
              end
              stst_pkg::OP_REMOVE: state <= S_SCAN;
              stst_pkg::OP_ADVANCE: begin
                if (stored_count == '0) begin
                  cursor <= '0;
                  status <= stst_pkg::ST_EMPTY;
                end else begin
                  cursor <= adv_cursor;
                end
              end
              stst_pkg::OP_CLEAR: begin
                stored_count <= '0;
                cursor       <= '0;
              end
              default: begin
                if (stored_count == '0) begin
                  status <= stst_pkg::ST_EMPTY;
                end
              end
            endcase
          end
        end
        S_SCAN: begin
          if (hit || scan_end) begin
            chk_vld <= 1'b0;
            mv_vld  <= 1'b0;
            pos     <= pos_cand[IDX_W-1:0];
            if (is_insert) begin
              if (hit && stored_dm == in_dm) begin
                status <= stst_pkg::ST_DUP;
                pos    <= '0;
                state  <= S_RDCUR;
              end else if (full) begin
                status <= stst_pkg::ST_FULL;
                pos    <= '0;
                state  <= S_RDCUR;
              end else begin
                // open a gap at the insert point, top entry first
                sidx   <= cnt_dec;
                n_left <= stored_count - pos_cand;
                state  <= S_SHIFT;
              end
            end else if (hit) begin
              // close the gap, lowest entry first
              sidx   <= pos_cand + CNT_W'(1);
              n_left <= cnt_dec - pos_cand;
              state  <= S_SHIFT;
            end else begin
              status <= stst_pkg::ST_MISSING;
              pos    <= '0;
              state  <= S_RDCUR;
            end
          end else if (idx < stored_count) begin
            chk_vld <= 1'b1;
            chk_idx <= idx[IDX_W-1:0];
            idx     <= idx + CNT_W'(1);
          end else begin
            chk_vld <= 1'b0;
          end
        end
        S_SHIFT: begin
          if (n_left != '0) begin
            mv_vld <= 1'b1;
            mv_dst <= is_insert ? dst_up[IDX_W-1:0] : dst_dn[IDX_W-1:0];
            sidx   <= is_insert ? dst_dn : dst_up;
            n_left <= n_left - CNT_W'(1);
          end else begin
            mv_vld <= 1'b0;
            if (!mv_vld) begin
              if (is_insert) begin
                state <= S_WRNEW;
              end else begin
                stored_count <= cnt_dec;
                cursor       <= rm_cursor;
                state        <= S_RDCUR;
              end
            end
          end
        end
        S_WRNEW: begin
          stored_count <= stored_count + CNT_W'(1);
          cursor       <= ins_cursor;
          state        <= S_RDCUR;
        end
        S_RDCUR: state <= S_FIN;
        S_FIN: begin
          // hold the result until the output register is free
          if (fin_go) begin
            m_data[2:0]  <= status;
            m_data[6:3]  <= pos_ext[3:0];
            m_data[11:7] <= cnt_ext[4:0];
            m_data[12]   <= cur_valid;
            m_data[17:13] <= cur_valid ? rd_data.hour : '0;
            m_data[23:18] <= cur_valid ? rd_data.minute : '0;
            m_data[39:24] <= cur_valid ? rd_data.amount : '0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stored_count <= CNT_MAX)
    else $error("entry count above table size");

  a_cursor_in_table: assert property (@(posedge clk) disable iff (rst)
    (stored_count != '0) |-> (CNT_W'(cursor) < stored_count))
    else $error("cursor beyond last entry");

  a_cursor_empty: assert property (@(posedge clk) disable iff (rst)
    (stored_count == '0) |-> (cursor == '0))
    else $error("cursor not zero on empty table");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRNEW) |=> (stored_count == $past(stored_count) + CNT_W'(1)))
    else $error("insert did not grow the table by one");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> (state != S_IDLE))
    else $error("accepted word not processed");

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for the sorted feed-time schedule table: directed, full-table and random runs.
module tb;

  localparam int MAX_ENTRIES      = stst_pkg::MAX_ENTRIES_DEF;
  localparam int MINUTES_PER_HOUR = 60;
  localparam int LIMIT_CYCLES     = 1_000_000;
  localparam int TAIL_CYCLES      = 2 * MAX_ENTRIES + 16;

  // op codes the block treats as read current
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [stst_pkg::AMOUNT_W-1:0] amount;
    logic [stst_pkg::MINUTE_W-1:0] minute;
    logic [stst_pkg::HOUR_W-1:0]   hour;
    logic [2:0]                    op;
  } sched_cmd_t;

  typedef struct packed {
    logic [stst_pkg::AMOUNT_W-1:0] cur_amount;
    logic [stst_pkg::MINUTE_W-1:0] cur_minute;
    logic [stst_pkg::HOUR_W-1:0]   cur_hour;
    logic                          cur_valid;
    logic [4:0]                    entry_count;
    logic [3:0]                    position;
    logic [2:0]                    status;
  } sched_result_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  // op[2:0], hour[7:3], minute[13:8], amount[29:14], zero[31:30]
  logic [stst_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  // status[2:0], position[6:3], entry_count[11:7], current_valid[12],
  // current_hour[17:13], current_minute[23:18], current_amount[39:24]
  logic [stst_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  // shadow of the schedule table
  stst_pkg::entry_t sched_tbl [MAX_ENTRIES];
  int     sched_count  = 0;
  int     sched_cursor = 0;

  sched_result_t pending_results [$];

  int  mismatches      = 0;
  int  ops_sent        = 0;
  int  results_checked = 0;
  int  full_rejects    = 0;
  int  cycle_count     = 0;
  int  stall_left      = 0;
  bit  idle_on         = 1'b1;

  sorted_time_schedule_table_core #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int minute_of_day(input stst_pkg::entry_t e);
    return int'(e.hour) * MINUTES_PER_HOUR + int'(e.minute);
  endfunction

  // Apply one operation to the shadow table and return the word the block should send.
  function automatic sched_result_t predict_schedule(input sched_cmd_t c);
    sched_result_t    r;
    stst_pkg::entry_t e;
    int               t_new;
    int               pos;
    int               hit;
    r = '0;
    e.hour   = c.hour;
    e.minute = c.minute;
    e.amount = c.amount;
    case (c.op)
      stst_pkg::OP_INSERT: begin
        t_new = minute_of_day(e);
        hit = -1;
        for (int i = 0; i < sched_count; i++)
          if (minute_of_day(sched_tbl[i]) == t_new) hit = i;
        if (c.hour > stst_pkg::HOUR_MAX || c.minute > stst_pkg::MINUTE_MAX) begin
          r.status = stst_pkg::ST_RANGE;
        end else if (hit >= 0) begin
          r.status = stst_pkg::ST_DUP;
        end else if (sched_count >= MAX_ENTRIES) begin
          r.status = stst_pkg::ST_FULL;
          full_rejects++;
        end else begin
          pos = 0;
          while (pos < sched_count && minute_of_day(sched_tbl[pos]) < t_new) pos++;
          for (int i = sched_count; i > pos; i--) sched_tbl[i] = sched_tbl[i-1];
          sched_tbl[pos] = e;
          // keep the cursor on the entry it pointed at
          if (sched_count == 0) sched_cursor = 0;
          else if (sched_cursor >= pos) sched_cursor++;
          sched_count++;
          r.status   = stst_pkg::ST_OK;
          r.position = pos[3:0];
        end
      end
      stst_pkg::OP_REMOVE: begin
        hit = -1;
        for (int i = 0; i < sched_count; i++)
          if (sched_tbl[i].hour == c.hour && sched_tbl[i].minute == c.minute) hit = i;
        if (hit < 0) begin
          r.status = stst_pkg::ST_MISSING;
        end else begin
          for (int i = hit + 1; i < sched_count; i++) sched_tbl[i-1] = sched_tbl[i];
          sched_count--;
          if (sched_cursor > hit) sched_cursor--;
          if (sched_cursor >= sched_count) sched_cursor = 0;
          r.status   = stst_pkg::ST_OK;
          r.position = hit[3:0];
        end
      end
      stst_pkg::OP_ADVANCE: begin
        if (sched_count == 0) begin
          sched_cursor = 0;
          r.status = stst_pkg::ST_EMPTY;
        end else begin
          sched_cursor = (sched_cursor + 1 >= sched_count) ? 0 : sched_cursor + 1;
          r.status = stst_pkg::ST_OK;
        end
      end
      stst_pkg::OP_CLEAR: begin
        sched_count  = 0;
        sched_cursor = 0;
        r.status = stst_pkg::ST_OK;
      end
      default: r.status = (sched_count == 0) ? stst_pkg::ST_EMPTY : stst_pkg::ST_OK;
    endcase
    r.entry_count = sched_count[4:0];
    if (sched_count > 0 && sched_cursor < sched_count) begin
      r.cur_valid  = 1'b1;
      r.cur_hour   = sched_tbl[sched_cursor].hour;
      r.cur_minute = sched_tbl[sched_cursor].minute;
      r.cur_amount = sched_tbl[sched_cursor].amount;
    end
    return r;
  endfunction

  // Drive one operation word; returns at the edge that accepts it, tvalid still high.
  task automatic send_op(input logic [2:0] op, input logic [stst_pkg::HOUR_W-1:0] hour,
                         input logic [stst_pkg::MINUTE_W-1:0] minute,
                         input logic [stst_pkg::AMOUNT_W-1:0] amount);
    sched_cmd_t c;
    int         gap;
    c.op     = op;
    c.hour   = hour;
    c.minute = minute;
    c.amount = amount;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata  <= stst_pkg::IN_DATA_W'(c);
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(predict_schedule(c));
    ops_sent++;
  endtask

  // Hold off the sender until every outstanding result has come back.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic test_directed();
    send_op(stst_pkg::OP_READ,    5'd0,  6'd0,  16'h0000);
    send_op(stst_pkg::OP_ADVANCE, 5'd0,  6'd0,  16'h0000);
    send_op(stst_pkg::OP_REMOVE,  5'd0,  6'd0,  16'h0000);
    send_op(stst_pkg::OP_INSERT,  5'd24, 6'd0,  16'h1111);
    send_op(stst_pkg::OP_INSERT,  5'd31, 6'd63, 16'hFFFF);
    send_op(stst_pkg::OP_INSERT,  5'd0,  6'd60, 16'h2222);
    send_op(stst_pkg::OP_INSERT,  5'd12, 6'd30, 16'h1234);
    send_op(stst_pkg::OP_INSERT,  5'd0,  6'd0,  16'h0000);
    send_op(stst_pkg::OP_INSERT,  5'd23, 6'd59, 16'hFFFF);
    send_op(stst_pkg::OP_INSERT,  5'd12, 6'd30, 16'h0001);
    send_op(stst_pkg::OP_READ,    5'd0,  6'd0,  16'h0000);
    // walk the cursor past the end and back
    repeat (3) send_op(stst_pkg::OP_ADVANCE, 5'd0, 6'd0, 16'h0000);
    send_op(stst_pkg::OP_REMOVE,  5'd31, 6'd63, 16'h0000);
    send_op(stst_pkg::OP_REMOVE,  5'd12, 6'd31, 16'h0000);
    send_op(stst_pkg::OP_REMOVE,  5'd0,  6'd0,  16'h0000);
    send_op(stst_pkg::OP_ADVANCE, 5'd0,  6'd0,  16'h0000);
    // cursor sits on the last entry, so removing it wraps to the front
    send_op(stst_pkg::OP_REMOVE,  5'd23, 6'd59, 16'h0000);
    for (int op = OP_SPARE_LO; op <= OP_SPARE_HI; op++)
      send_op(op[2:0], 5'd31, 6'd63, 16'hFFFF);
    send_op(stst_pkg::OP_CLEAR,   5'd0,  6'd0,  16'h0000);
    send_op(stst_pkg::OP_READ,    5'd0,  6'd0,  16'h0000);
    send_op(stst_pkg::OP_INSERT,  5'd5,  6'd5,  16'hA5A5);
  endtask

  task automatic test_full_table();
    send_op(stst_pkg::OP_CLEAR, 5'd0, 6'd0, 16'h0000);
    // descending times: each insert lands at the front and shifts the whole table
    for (int k = 0; k < MAX_ENTRIES; k++)
      send_op(stst_pkg::OP_INSERT, 5'(23 - k), 6'($urandom_range(0, 59)), 16'($urandom));
    send_op(stst_pkg::OP_INSERT, 5'd3, 6'd15, 16'hBEEF);
    send_op(stst_pkg::OP_INSERT, sched_tbl[5].hour, sched_tbl[5].minute, 16'h0BAD);
    send_op(stst_pkg::OP_INSERT, 5'd25, 6'd0, 16'h0000);
    repeat (MAX_ENTRIES + 1) send_op(stst_pkg::OP_ADVANCE, 5'd0, 6'd0, 16'h0000);
    send_op(stst_pkg::OP_REMOVE, sched_tbl[sched_cursor].hour,
            sched_tbl[sched_cursor].minute, 16'h0);
    send_op(stst_pkg::OP_INSERT, 5'd3, 6'd15, 16'hBEEF);
    send_op(stst_pkg::OP_CLEAR, 5'd0, 6'd0, 16'h0000);
    // ascending times: each insert appends
    for (int k = 0; k < MAX_ENTRIES; k++)
      send_op(stst_pkg::OP_INSERT, 5'(k), 6'($urandom_range(0, 59)), 16'($urandom));
    repeat (MAX_ENTRIES - 1) send_op(stst_pkg::OP_ADVANCE, 5'd0, 6'd0, 16'h0000);
    send_op(stst_pkg::OP_REMOVE, sched_tbl[sched_count-1].hour,
            sched_tbl[sched_count-1].minute, 16'h0);
    repeat (3)
      send_op(stst_pkg::OP_REMOVE, sched_tbl[sched_cursor].hour,
              sched_tbl[sched_cursor].minute, 16'h0);
    send_op(stst_pkg::OP_READ, 5'd0, 6'd0, 16'h0000);
  endtask

  task automatic test_random(input int n_items);
    int sel;
    int idx;
    for (int k = 0; k < n_items; k++) begin
      if (k % 128 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if (k >= n_items - 200) idle_on = 1'b0;
      if (k == n_items / 2) wait_drained();
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        send_op(stst_pkg::OP_INSERT, 5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)),
                16'($urandom));
      end else if (sel < 50 && sched_count > 0) begin
        idx = $urandom_range(0, sched_count - 1);
        send_op(stst_pkg::OP_REMOVE, sched_tbl[idx].hour, sched_tbl[idx].minute,
                16'($urandom));
      end else if (sel < 55) begin
        send_op(stst_pkg::OP_REMOVE, 5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)),
                16'($urandom));
      end else if (sel < 60 && sched_count > 0) begin
        idx = $urandom_range(0, sched_count - 1);
        send_op(stst_pkg::OP_INSERT, sched_tbl[idx].hour, sched_tbl[idx].minute,
                16'($urandom));
      end else if (sel < 75) begin
        send_op(stst_pkg::OP_ADVANCE, 5'($urandom), 6'($urandom), 16'($urandom));
      end else if (sel < 89) begin
        send_op(stst_pkg::OP_READ, 5'($urandom), 6'($urandom), 16'($urandom));
      end else if (sel < 90) begin
        send_op(stst_pkg::OP_CLEAR, 5'($urandom), 6'($urandom), 16'($urandom));
      end else begin
        send_op(3'($urandom_range(stst_pkg::OP_INSERT, OP_SPARE_HI)),
                5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)), 16'($urandom));
      end
    end
  endtask

  // Result side: random stall bursts while idling is enabled.
  always @(posedge clk) begin
    if (!idle_on) begin
      stall_left    <= 0;
      m_axis_tready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= $urandom_range(0, 12);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [15:0] want_v,
                             input logic [15:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_results
    sched_result_t got;
    sched_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_results.size() == 0) begin
        $error("result word %h with no operation outstanding", m_axis_tdata);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("status",         16'(want.status),      16'(got.status));
        check_field("position",       16'(want.position),    16'(got.position));
        check_field("entry_count",    16'(want.entry_count), 16'(got.entry_count));
        check_field("current_valid",  16'(want.cur_valid),   16'(got.cur_valid));
        check_field("current_hour",   16'(want.cur_hour),    16'(got.cur_hour));
        check_field("current_minute", 16'(want.cur_minute),  16'(got.cur_minute));
        check_field("current_amount", want.cur_amount,       got.cur_amount);
        results_checked++;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    wait_drained();
    test_full_table();
    wait_drained();
    test_random(1550);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Ran %0d schedule operations (directed, full-table, random); %0d results checked,",
             ops_sent, results_checked);
    $display("%0d inserts rejected on a full table, %0d field mismatches.",
             full_rejects, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
